// ----- rtl/nnq_pkg.sv -----
package nnq_pkg;

  localparam int unsigned NUM_OCTAVES      = 9;
  localparam int unsigned NOTES_PER_OCTAVE = 12;
  localparam int unsigned FREQ_FRAC_BITS   = 8;

  localparam int unsigned TBL_LEN = NUM_OCTAVES * NOTES_PER_OCTAVE;
  localparam int unsigned IDX_W   = $clog2(TBL_LEN);
  localparam int unsigned FREQ_W  = 22;
  localparam int unsigned SUM_W   = FREQ_W + 1;
  localparam int unsigned PROD_W  = FREQ_W + SUM_W;
  localparam int unsigned NOTE_W  = 7;
  localparam int unsigned DEV_W   = 16;
  localparam int unsigned NUM_W   = SUM_W + DEV_W;
  localparam int unsigned DEN_W   = SUM_W + 1;
  localparam int unsigned CNT_W   = $clog2(DEV_W);

  localparam logic [FREQ_W-1:0] FreqMax = {FREQ_W{1'b1}};

  // 2^(s/12) in unsigned q32
  localparam logic [63:0] SemiRatioQ32 [NOTES_PER_OCTAVE] = '{
    64'd4294967296, 64'd4550359342, 64'd4820937789, 64'd5107605668,
    64'd5411319705, 64'd5733093519, 64'd6074001000, 64'd6435179895,
    64'd6817835604, 64'd7223245206, 64'd7652761717, 64'd8107818610
  };

  typedef logic [FREQ_W-1:0] freq_rom_t [TBL_LEN];

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_CMP,
    ST_DIVS,
    ST_DIVW,
    ST_DONE
  } nnq_state_e;

  function automatic freq_rom_t build_rom();
    freq_rom_t   r;
    logic [63:0] v;
    logic [63:0] e;
    int          n;
    for (int o = 0; o < NUM_OCTAVES; o++) begin
      for (int s = 0; s < NOTES_PER_OCTAVE; s++) begin
        v = 64'd55 * SemiRatioQ32[s];
        n = 34 - o - FREQ_FRAC_BITS;
        if (n < 1) begin
          e = 64'(FreqMax);
        end else if (n > 63) begin
          e = '0;
        end else begin
          e = (v + (64'd1 << (n - 1))) >> n;
        end
        if (e > 64'(FreqMax)) begin
          e = 64'(FreqMax);
        end
        r[o * NOTES_PER_OCTAVE + s] = e[FREQ_W-1:0];
      end
    end
    return r;
  endfunction

  localparam freq_rom_t NoteFreqRom = build_rom();

endpackage

// ----- rtl/nnq_div.sv -----
module nnq_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [nnq_pkg::FREQ_W-1:0]  best_d_i,
  input  logic [nnq_pkg::SUM_W-1:0]   best_s_i,
  output logic                        done_o,
  output logic [nnq_pkg::DEV_W-1:0]   quot_o
);
  import nnq_pkg::*;

  logic [NUM_W-1:0] num;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q;
  logic [DEV_W-1:0] lo_q;
  logic [DEV_W-1:0] quot_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [DEN_W:0]   trial;
  logic             ge;

  // rounded numerator: d * 2^16 + s
  assign num = NUM_W'({best_d_i, {DEV_W{1'b0}}}) + NUM_W'(best_s_i);

  assign trial = {rem_q, lo_q[DEV_W-1]};
  assign ge    = trial >= (DEN_W+1)'(den_q);
  assign rem_d = ge ? DEN_W'(trial - (DEN_W+1)'(den_q)) : DEN_W'(trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DEV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= DEN_W'(num[NUM_W-1:DEV_W]);
      lo_q   <= num[DEV_W-1:0];
      den_q  <= {best_s_i, 1'b0};
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      lo_q   <= {lo_q[DEV_W-2:0], 1'b0};
      quot_q <= {quot_q[DEV_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ----- rtl/nearest_note_quantizer_top.sv -----
// walk: each accepted word steps through the 108-entry note table, one ST_MUL and one ST_CMP per entry;
// an exact match ends the walk early, otherwise the 16-step serial divider then forms the deviation
// accept: a new word is taken only in ST_IDLE, after the last result has moved to the output registers;
// a held output word stalls ST_DONE and so delays the next accept
// reset: asynchronous active-low, clears sequencer and valid flags; the note table is a rom
module nearest_note_quantizer_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [nnq_pkg::FREQ_W-1:0]      freq_in_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [nnq_pkg::NOTE_W-1:0]      note_index_o,
  output logic [nnq_pkg::DEV_W-1:0]       deviation_o,
  output logic                            exact_match_o
);
  import nnq_pkg::*;

  nnq_state_e        state_q, state_d;
  logic [FREQ_W-1:0] freq_q;
  logic [IDX_W-1:0]  idx_q;
  logic [FREQ_W-1:0] d_q;
  logic [SUM_W-1:0]  s_q;
  logic [FREQ_W-1:0] best_d_q;
  logic [SUM_W-1:0]  best_s_q;
  logic [IDX_W-1:0]  best_i_q;
  logic [PROD_W-1:0] prod_a_q;
  logic [PROD_W-1:0] prod_b_q;
  logic              exact_q;
  logic              out_valid_q;
  logic [NOTE_W-1:0] note_q;
  logic [DEV_W-1:0]  dev_q;
  logic              exact_out_q;

  logic              last;
  logic [IDX_W-1:0]  rom_idx;
  logic [FREQ_W-1:0] fi;
  logic              out_free;
  logic              div_start;
  logic              div_done;
  logic [DEV_W-1:0]  div_quot;

  assign last     = idx_q == IDX_W'(TBL_LEN - 1);
  assign rom_idx  = (state_q == ST_CMP && !last) ? idx_q + 1'b1 : idx_q;
  assign fi       = NoteFreqRom[rom_idx];
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    div_start  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: state_d = ST_MUL;
      ST_MUL: begin
        state_d = (d_q == '0) ? ST_DONE : ST_CMP;
      end
      ST_CMP: begin
        state_d = last ? ST_DIVS : ST_MUL;
      end
      ST_DIVS: begin
        div_start = 1'b1;
        state_d   = ST_DIVW;
      end
      ST_DIVW: begin
        if (div_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        freq_q  <= freq_in_i;
        idx_q   <= '0;
        exact_q <= 1'b0;
      end
      ST_LOAD, ST_CMP: begin
        if (state_q == ST_CMP) begin
          if (idx_q == '0 || prod_a_q < prod_b_q) begin
            best_d_q <= d_q;
            best_s_q <= s_q;
            best_i_q <= idx_q;
          end
          if (!last) begin
            idx_q <= idx_q + 1'b1;
          end
        end
        d_q <= (fi > freq_q) ? fi - freq_q : freq_q - fi;
        s_q <= SUM_W'(fi) + SUM_W'(freq_q);
      end
      ST_MUL: begin
        if (d_q == '0) begin
          exact_q  <= 1'b1;
          best_i_q <= idx_q;
        end
        prod_a_q <= PROD_W'(d_q) * PROD_W'(best_s_q);
        prod_b_q <= PROD_W'(best_d_q) * PROD_W'(s_q);
      end
      ST_DONE: begin
        if (out_free) begin
          note_q      <= NOTE_W'(best_i_q);
          dev_q       <= exact_q ? '0 : div_quot;
          exact_out_q <= exact_q;
        end
      end
      default: ;
    endcase
  end

  nnq_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .best_d_i (best_d_q),
    .best_s_i (best_s_q),
    .done_o   (div_done),
    .quot_o   (div_quot)
  );

  assign out_valid_o   = out_valid_q;
  assign note_index_o  = note_q;
  assign deviation_o   = dev_q;
  assign exact_match_o = exact_out_q;

  a_accept_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == ST_LOAD)
    else $error("accepted word did not start the table walk");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> idx_q < IDX_W'(TBL_LEN))
    else $error("table index out of range");

  a_exact_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && exact_match_o |-> deviation_o == '0)
    else $error("exact match with nonzero deviation");

  a_dev_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> deviation_o <= DEV_W'(32768))
    else $error("deviation above 2.0");

  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIVW)
    else $error("divider finished outside its wait state");

endmodule
